>>> sv/ddpi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pose integrator package
// Shared widths, the command struct and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ddpi_pkg;

  localparam int unsigned StampW      = 52;
  localparam int unsigned PosW        = 48;
  localparam int unsigned AngW        = 32;
  localparam int unsigned RateW       = 32;
  localparam int unsigned CordicW     = 36;
  localparam int unsigned CordicStagesDef = 24;
  localparam int unsigned CfgAddrW    = 5;

  localparam logic [CfgAddrW-1:0] ADDR_INIT_X   = 5'd0;
  localparam logic [CfgAddrW-1:0] ADDR_INIT_Y   = 5'd8;
  localparam logic [CfgAddrW-1:0] ADDR_INIT_YAW = 5'd16;

  localparam logic signed [CordicW-1:0] CordicGain = 36'sd652032874;
  localparam logic signed [CordicW-1:0] OneQ30     = 36'sd1073741824;
  localparam logic [31:0] InvPiQ32 = 32'd1367130551;

  // Datapath operations
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_LOAD  = 3'd1;
  localparam logic [2:0] OP_PREP  = 3'd2;
  localparam logic [2:0] OP_CSTEP = 3'd3;
  localparam logic [2:0] OP_MUL1  = 3'd4;
  localparam logic [2:0] OP_MUL2  = 3'd5;
  localparam logic [2:0] OP_MUL3  = 3'd6;
  localparam logic [2:0] OP_FIN   = 3'd7;

  typedef struct packed {
    logic [2:0] op;
    logic [4:0] step;
  } ddpi_cmd_t;

  function automatic logic signed [CordicW-1:0] atan_lut(input logic [4:0] i);
    logic signed [CordicW-1:0] r;
    begin
      case (i)
        5'd0:  r = 36'sd536870912;
        5'd1:  r = 36'sd316933406;
        5'd2:  r = 36'sd167458907;
        5'd3:  r = 36'sd85004756;
        5'd4:  r = 36'sd42667331;
        5'd5:  r = 36'sd21354465;
        5'd6:  r = 36'sd10679838;
        5'd7:  r = 36'sd5340245;
        5'd8:  r = 36'sd2670163;
        5'd9:  r = 36'sd1335087;
        5'd10: r = 36'sd667544;
        5'd11: r = 36'sd333772;
        5'd12: r = 36'sd166886;
        5'd13: r = 36'sd83443;
        5'd14: r = 36'sd41722;
        5'd15: r = 36'sd20861;
        5'd16: r = 36'sd10430;
        5'd17: r = 36'sd5215;
        5'd18: r = 36'sd2608;
        5'd19: r = 36'sd1304;
        5'd20: r = 36'sd652;
        5'd21: r = 36'sd326;
        5'd22: r = 36'sd163;
        5'd23: r = 36'sd81;
        5'd24: r = 36'sd41;
        5'd25: r = 36'sd20;
        5'd26: r = 36'sd10;
        5'd27: r = 36'sd5;
        5'd28: r = 36'sd3;
        5'd29: r = 36'sd1;
        5'd30: r = 36'sd1;
        default: r = 36'sd0;
      endcase
      return r;
    end
  endfunction

endpackage

>>> sv/ddpi_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pose integrator channels
// Valid/ready channels for input samples and pose results.
// ----------------------------------------------------------------------------
interface ddpi_in_if;
  logic                             valid;
  logic                             ready;
  logic [ddpi_pkg::StampW-1:0]      timestamp;
  logic signed [ddpi_pkg::RateW-1:0] linear_speed;
  logic signed [ddpi_pkg::RateW-1:0] turn_rate;
  modport source (output valid, timestamp, linear_speed, turn_rate, input ready);
  modport sink   (input valid, timestamp, linear_speed, turn_rate, output ready);
endinterface

interface ddpi_out_if;
  logic                              valid;
  logic                              ready;
  logic [ddpi_pkg::StampW-1:0]       stamp_out;
  logic signed [ddpi_pkg::PosW-1:0]  pos_x;
  logic signed [ddpi_pkg::PosW-1:0]  pos_y;
  logic [ddpi_pkg::AngW-1:0]         heading;
  logic signed [31:0]                quat_z;
  logic signed [31:0]                quat_w;
  modport source (output valid, stamp_out, pos_x, pos_y, heading, quat_z, quat_w,
                  input ready);
  modport sink   (input valid, stamp_out, pos_x, pos_y, heading, quat_z, quat_w,
                  output ready);
endinterface

>>> sv/ddpi_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pose integrator controller
// Sequences load, two CORDIC runs, the multiply steps and result hand-off.
// ----------------------------------------------------------------------------
module ddpi_ctrl #(
  parameter int unsigned CORDIC_STAGES = ddpi_pkg::CordicStagesDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output ddpi_pkg::ddpi_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ROT  = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_MUL3 = 3'd4;
  localparam logic [2:0] S_HROT = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;
  localparam logic [4:0] LastStep = 5'(CORDIC_STAGES - 1);

  logic [2:0] state_r, state_nxt;
  logic [4:0] step_r, step_nxt;
  logic       have_r, have_nxt;
  logic       acc;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign acc       = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    have_nxt  = have_r;
    cmd       = '{op: ddpi_pkg::OP_NONE, step: step_r};
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (!have_r) begin
            cmd.op   = ddpi_pkg::OP_LOAD;
            have_nxt = 1'b1;
          end else begin
            cmd.op    = ddpi_pkg::OP_PREP;
            step_nxt  = '0;
            state_nxt = S_ROT;
          end
        end
      end
      S_ROT, S_HROT: begin
        cmd.op   = ddpi_pkg::OP_CSTEP;
        step_nxt = step_r + 5'd1;
        if (step_r == LastStep) begin
          state_nxt = (state_r == S_ROT) ? S_MUL1 : S_FIN;
        end
      end
      S_MUL1: begin
        cmd.op = ddpi_pkg::OP_MUL1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.op = ddpi_pkg::OP_MUL2;
        state_nxt = S_MUL3;
      end
      S_MUL3: begin
        cmd.op    = ddpi_pkg::OP_MUL3;
        step_nxt  = '0;
        state_nxt = S_HROT;
      end
      S_FIN: begin
        cmd.op = ddpi_pkg::OP_FIN;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      have_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      have_r  <= have_nxt;
    end
  end

endmodule

>>> sv/ddpi_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pose integrator datapath
// Pose state, one shared CORDIC rotator, staged multiplies, result registers.
// ----------------------------------------------------------------------------
module ddpi_dp (
  input  logic                               clk,
  input  ddpi_pkg::ddpi_cmd_t                cmd,
  input  logic [ddpi_pkg::StampW-1:0]        in_stamp,
  input  logic signed [ddpi_pkg::RateW-1:0]  in_v,
  input  logic signed [ddpi_pkg::RateW-1:0]  in_w,
  input  logic [ddpi_pkg::PosW-1:0]          init_x,
  input  logic [ddpi_pkg::PosW-1:0]          init_y,
  input  logic [ddpi_pkg::AngW-1:0]          init_yaw,
  output logic [ddpi_pkg::StampW-1:0]        res_stamp,
  output logic [ddpi_pkg::PosW-1:0]          res_x,
  output logic [ddpi_pkg::PosW-1:0]          res_y,
  output logic [ddpi_pkg::AngW-1:0]          res_yaw,
  output logic [31:0]                        res_qz,
  output logic [31:0]                        res_qw
);

  localparam int unsigned CW = ddpi_pkg::CordicW;

  logic [ddpi_pkg::StampW-1:0] last_r, stamp_r;
  logic [ddpi_pkg::PosW-1:0]   x_r, y_r;
  logic [31:0]                 yaw_r;
  logic signed [31:0]          v_r, w_r, dt_r;
  logic signed [CW-1:0]        cx_r, cy_r, cz_r;
  logic                        flip_r;
  logic signed [63:0]          pc_r, ps_r, wdt_r;
  logic [63:0]                 lo_r, hi_r;
  logic                        neg_r;
  logic [31:0]                 qz_r, qw_r;

  // Time difference, saturated to a signed 32-bit count
  logic signed [53:0] dt_full;
  logic signed [31:0] dt_sat;
  assign dt_full = $signed({2'b00, in_stamp}) - $signed({2'b00, last_r});
  always_comb begin
    if (dt_full > 54'sd2147483647)       dt_sat = 32'sh7FFFFFFF;
    else if (dt_full < -54'sd2147483648) dt_sat = 32'sh80000000;
    else                                 dt_sat = dt_full[31:0];
  end

  // Quadrant fold of a 2*pi angle
  function automatic logic [CW:0] fold(input logic [31:0] a);
    logic [31:0] b;
    logic        f;
    begin
      f = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
      b = f ? (a + 32'h80000000) : a;
      return {f, {{(CW-32){b[31]}}, b}};
    end
  endfunction

  logic [CW:0] fold_full;
  assign fold_full = fold({yaw_r[30:0], 1'b0});

  // One CORDIC micro-rotation
  logic signed [CW-1:0] xs, ys, xn, yn, zn, at;
  assign xs = cx_r >>> cmd.step;
  assign ys = cy_r >>> cmd.step;
  assign at = ddpi_pkg::atan_lut(cmd.step);
  always_comb begin
    if (!cz_r[CW-1]) begin
      xn = cx_r - ys;
      yn = cy_r + xs;
      zn = cz_r - at;
    end else begin
      xn = cx_r + ys;
      yn = cy_r - xs;
      zn = cz_r + at;
    end
  end

  function automatic logic signed [CW-1:0] clampf(input logic signed [CW-1:0] a,
                                                   input logic f);
    logic signed [CW-1:0] r;
    begin
      r = a;
      if (r > ddpi_pkg::OneQ30) r = ddpi_pkg::OneQ30;
      if (r < -ddpi_pkg::OneQ30) r = -ddpi_pkg::OneQ30;
      return f ? -r : r;
    end
  endfunction

  logic signed [CW-1:0] cos_c, sin_c;
  assign cos_c = clampf(cx_r, flip_r);
  assign sin_c = clampf(cy_r, flip_r);

  // Rounded products
  logic signed [63:0] pc16, ps16, tx, ty;
  assign pc16 = (pc_r + 64'sd536870912) >>> 30;
  assign ps16 = (ps_r + 64'sd536870912) >>> 30;
  assign tx   = (pc_r + 64'sd524288) >>> 20;
  assign ty   = (ps_r + 64'sd524288) >>> 20;

  logic [63:0] wmag, yr;
  logic [31:0] dyaw;
  assign wmag = wdt_r[63] ? (64'd0 - wdt_r) : wdt_r;
  assign yr   = (hi_r + {32'd0, lo_r[63:32]}) >> 6;
  assign dyaw = neg_r ? (32'd0 - yr[31:0]) : yr[31:0];

  // New heading and its fold for the half-angle run
  logic [31:0] yaw_new;
  logic [CW:0] fold_new;
  assign yaw_new  = yaw_r + dyaw;
  assign fold_new = fold(yaw_new);

  always_ff @(posedge clk) begin
    case (cmd.op)
      ddpi_pkg::OP_LOAD: begin
        last_r <= in_stamp;
        x_r    <= init_x;
        y_r    <= init_y;
        yaw_r  <= init_yaw;
      end
      ddpi_pkg::OP_PREP: begin
        stamp_r <= in_stamp;
        last_r  <= in_stamp;
        v_r     <= in_v;
        w_r     <= in_w;
        dt_r    <= dt_sat;
        cx_r    <= ddpi_pkg::CordicGain;
        cy_r    <= '0;
        cz_r    <= fold_full[CW-1:0];
        flip_r  <= fold_full[CW];
      end
      ddpi_pkg::OP_CSTEP: begin
        cx_r <= xn;
        cy_r <= yn;
        cz_r <= zn;
      end
      ddpi_pkg::OP_MUL1: begin
        pc_r  <= 64'(v_r) * 64'(cos_c);
        ps_r  <= 64'(v_r) * 64'(sin_c);
        wdt_r <= 64'(w_r) * 64'(dt_r);
      end
      ddpi_pkg::OP_MUL2: begin
        pc_r  <= pc16 * 64'(dt_r);
        ps_r  <= ps16 * 64'(dt_r);
        neg_r <= wdt_r[63];
        lo_r  <= {32'd0, wmag[31:0]} * {32'd0, ddpi_pkg::InvPiQ32} + 64'h20_0000_0000;
        hi_r  <= {32'd0, wmag[63:32]} * {32'd0, ddpi_pkg::InvPiQ32};
      end
      ddpi_pkg::OP_MUL3: begin
        x_r    <= x_r + tx[47:0];
        y_r    <= y_r + ty[47:0];
        yaw_r  <= yaw_new;
        cx_r   <= ddpi_pkg::CordicGain;
        cy_r   <= '0;
        cz_r   <= fold_new[CW-1:0];
        flip_r <= fold_new[CW];
      end
      ddpi_pkg::OP_FIN: begin
        qz_r <= sin_c[31:0];
        qw_r <= cos_c[31:0];
      end
      default: ;
    endcase
  end

  assign res_stamp = stamp_r;
  assign res_x     = x_r;
  assign res_y     = y_r;
  assign res_yaw   = yaw_r;
  assign res_qz    = qz_r;
  assign res_qw    = qw_r;

endmodule

>>> sv/diff_drive_pose_integrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Differential-drive pose integrator
// Dead-reckoning odometry: integrates speed and turn rate into a pose.
// ----------------------------------------------------------------------------
// The block takes one sample at a time. The first sample after reset loads
// the pose from the initial_* registers and produces no result. For every
// later sample one shared CORDIC rotator runs once for the current heading
// and once for the new half angle, with three multiply steps in between;
// then the quaternion is latched and the result is offered. The result
// stays until it is taken; the next sample is taken after that. Registers:
// 0x00 initial_x, 0x08 initial_y, 0x10 initial_yaw, 64-bit data; they act
// only on the first sample after reset.
module diff_drive_pose_integrator #(
  parameter int unsigned CORDIC_STAGES = ddpi_pkg::CordicStagesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  ddpi_in_if.sink     in_ch,
  ddpi_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [ddpi_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [ddpi_pkg::PosW-1:0] init_x_r, init_y_r;
  logic [ddpi_pkg::AngW-1:0] init_yaw_r;
  logic                      wr_en;
  ddpi_pkg::ddpi_cmd_t       cmd;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;

  // Register file: write on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_x_r   <= '0;
      init_y_r   <= '0;
      init_yaw_r <= '0;
    end else if (wr_en) begin
      unique case (cfg_paddr)
        ddpi_pkg::ADDR_INIT_X:   init_x_r   <= cfg_pwdata[47:0];
        ddpi_pkg::ADDR_INIT_Y:   init_y_r   <= cfg_pwdata[47:0];
        ddpi_pkg::ADDR_INIT_YAW: init_yaw_r <= cfg_pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr)
      ddpi_pkg::ADDR_INIT_X:   cfg_prdata = {16'd0, init_x_r};
      ddpi_pkg::ADDR_INIT_Y:   cfg_prdata = {16'd0, init_y_r};
      ddpi_pkg::ADDR_INIT_YAW: cfg_prdata = {32'd0, init_yaw_r};
      default:                 cfg_prdata = '0;
    endcase
  end

  ddpi_ctrl #(.CORDIC_STAGES(CORDIC_STAGES)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  ddpi_dp u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .in_stamp  (in_ch.timestamp),
    .in_v      (in_ch.linear_speed),
    .in_w      (in_ch.turn_rate),
    .init_x    (init_x_r),
    .init_y    (init_y_r),
    .init_yaw  (init_yaw_r),
    .res_stamp (out_ch.stamp_out),
    .res_x     (out_ch.pos_x),
    .res_y     (out_ch.pos_y),
    .res_yaw   (out_ch.heading),
    .res_qz    (out_ch.quat_z),
    .res_qw    (out_ch.quat_w)
  );

endmodule

>>> sv/ddpi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pose integrator checker
// Port-level properties of the integrator, bound to the top level.
// ----------------------------------------------------------------------------
module ddpi_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic cfg_pready
);

  a_no_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("sample taken while result pending");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid) else $error("result too early");

  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("pready low");

endmodule

bind diff_drive_pose_integrator ddpi_checker u_ddpi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .cfg_pready (cfg_pready)
);

>>> bench/tb_diff_drive_pose_integrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pose integrator testbench
// Drives odometry samples into the pose integrator and checks every pose
// against a fixed-point dead-reckoning predictor kept in step with the block.
// ----------------------------------------------------------------------------
// Stimulus starts with a directed table: extreme start pose, zero and
// saturated time steps, time running backwards, position wrap-around and
// extreme speeds. Poses in the table that can be read off directly (time step
// of zero, or no motion) are typed in; the rest come from the predictor.
// Random samples follow in three handshake mixes: a lazy receiver, a lazy
// sender, then both running flat out. Registers are rewritten between mixes;
// they only matter on the first sample after reset, which the predictor
// mirrors.
module tb_diff_drive_pose_integrator;

  localparam int unsigned Stages    = 24;
  localparam int unsigned DrainCyc  = 2 * Stages + 16;
  localparam int unsigned RandItems = 578;
  localparam logic [ddpi_pkg::CfgAddrW-1:0] AddrSpare = 5'd24;  // no register here

  typedef struct {
    bit [51:0] stamp;
    bit [47:0] x;
    bit [47:0] y;
    bit [31:0] hdg;
    bit [31:0] qz;
    bit [31:0] qw;
  } pose_t;

  typedef struct {
    bit [51:0] ts;
    bit [31:0] v;
    bit [31:0] w;
    bit        typed;   // expected x, y, heading given below
    bit [47:0] ex;
    bit [47:0] ey;
    bit [31:0] eh;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [ddpi_pkg::CfgAddrW-1:0] cfg_paddr;
  logic [63:0] cfg_pwdata, cfg_prdata;

  ddpi_in_if  in_ch ();
  ddpi_out_if out_ch ();

  diff_drive_pose_integrator #(.CORDIC_STAGES(Stages)) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Predictor state: register copies and the integrated pose
  bit [47:0] start_x, start_y;
  bit [31:0] start_yaw;
  bit        time_seen;
  bit [51:0] prev_stamp;
  bit [47:0] pose_x, pose_y;
  bit [31:0] pose_yaw;

  pose_t pending_poses[$];
  int    errors;
  int    samples_sent;
  int    poses_checked;
  int    in_idle_pct;
  int    out_idle_pct;
  bit [51:0] drive_stamp;

  // Arctangent steps on a 2^32 = 2*pi circle
  localparam longint AtanStep [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous hard stop well beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Rotate a unit vector to the given angle; Q1.30 cosine and sine out
  function automatic void rotate_unit(input bit [31:0] ang, output longint co,
                                      output longint si);
    bit [31:0] a;
    bit        flip;
    longint    x, y, z, t;
    a    = ang;
    flip = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
    // fold the left half plane onto the right one and negate afterwards
    if (flip) a = a + 32'h8000_0000;
    z = $signed(a);
    x = 652032874;
    y = 0;
    for (int i = 0; i < Stages; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z = z - AtanStep[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z = z + AtanStep[i];
      end
      x = t;
    end
    if (x > 64'sd1073741824) x = 64'sd1073741824;
    if (x < -64'sd1073741824) x = -64'sd1073741824;
    if (y > 64'sd1073741824) y = 64'sd1073741824;
    if (y < -64'sd1073741824) y = -64'sd1073741824;
    co = flip ? -x : x;
    si = flip ? -y : y;
  endfunction

  // One axis of the Euler step, rounding half up twice, wrapping at 48 bits
  function automatic bit [47:0] move_axis(bit [47:0] pos, longint v, longint trig,
                                          longint dt);
    longint p16, term;
    p16  = (v * trig + (64'sd1 <<< 29)) >>> 30;
    term = (p16 * dt + (64'sd1 <<< 19)) >>> 20;
    return pos + term[47:0];
  endfunction

  // w*dt scaled to binary angle, rounded half away from zero
  function automatic bit [31:0] turn_angle(longint w, longint dt);
    longint    wdt;
    bit [63:0] mag, lo, hi, r;
    wdt = w * dt;
    mag = (wdt < 0) ? -wdt : wdt;
    lo  = {32'b0, mag[31:0]} * 64'd1367130551 + (64'd1 << 37);
    hi  = (mag >> 32) * 64'd1367130551;
    r   = (hi + (lo >> 32)) >> 6;
    return (wdt < 0) ? -r[31:0] : r[31:0];
  endfunction

  // Advance the pose for one accepted sample and queue the pose it yields
  task automatic integrate_sample(bit [51:0] ts, bit [31:0] v, bit [31:0] w);
    longint dt, c, s, hc, hs;
    pose_t  p;
    if (!time_seen) begin
      // first sample only loads the start pose
      time_seen  = 1'b1;
      prev_stamp = ts;
      pose_x     = start_x;
      pose_y     = start_y;
      pose_yaw   = start_yaw;
      return;
    end
    dt = $signed({12'b0, ts}) - $signed({12'b0, prev_stamp});
    if (dt > 64'sd2147483647) dt = 64'sd2147483647;
    if (dt < -64'sd2147483648) dt = -64'sd2147483648;
    rotate_unit(pose_yaw << 1, c, s);
    pose_x   = move_axis(pose_x, $signed(v), c, dt);
    pose_y   = move_axis(pose_y, $signed(v), s, dt);
    pose_yaw = pose_yaw + turn_angle($signed(w), dt);
    rotate_unit(pose_yaw, hc, hs);
    prev_stamp = ts;
    p.stamp = ts;
    p.x     = pose_x;
    p.y     = pose_y;
    p.hdg   = pose_yaw;
    p.qz    = hs[31:0];
    p.qw    = hc[31:0];
    pending_poses.push_back(p);
  endtask

  task automatic reg_write(logic [ddpi_pkg::CfgAddrW-1:0] addr, logic [63:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    // mirror the register file; it only takes effect before the first sample
    if (addr == ddpi_pkg::ADDR_INIT_X) start_x = data[47:0];
    else if (addr == ddpi_pkg::ADDR_INIT_Y) start_y = data[47:0];
    else if (addr == ddpi_pkg::ADDR_INIT_YAW) start_yaw = data[31:0];
  endtask

  task automatic set_start_pose(bit [47:0] x, bit [47:0] y, bit [31:0] yaw);
    reg_write(ddpi_pkg::ADDR_INIT_X, {{16{x[47]}}, x});
    reg_write(ddpi_pkg::ADDR_INIT_Y, {{16{y[47]}}, y});
    reg_write(ddpi_pkg::ADDR_INIT_YAW, {32'b0, yaw});
  endtask

  // Offer one sample, holding valid across back-to-back transfers
  task automatic send_sample(bit [51:0] ts, bit [31:0] v, bit [31:0] w);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.timestamp    <= ts;
    in_ch.linear_speed <= v;
    in_ch.turn_rate    <= w;
    do @(posedge clk); while (!in_ch.ready);
    integrate_sample(ts, v, w);
    drive_stamp = ts;
    samples_sent++;
  endtask

  // Wait for every pose, then let a result-less sample settle
  task automatic drain;
    @(posedge clk);
    in_ch.valid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (DrainCyc) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    int        sel;
    bit [51:0] ts;
    bit [31:0] v, w;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(99);
      if (sel < 4) ts = 52'({$urandom, $urandom});
      else if (sel < 10) ts = drive_stamp - $urandom_range(0, 1 << 22);
      else if (sel < 14) ts = drive_stamp + (52'($urandom) << $urandom_range(0, 20));
      else ts = drive_stamp + $urandom_range(0, 1 << 21);
      v = ($urandom_range(99) < 25) ? $urandom
          : 32'($urandom_range(0, 16 << 16)) - 32'(8 << 16);
      w = ($urandom_range(99) < 25) ? $urandom
          : 32'($urandom_range(0, 8 << 16)) - 32'(4 << 16);
      send_sample(ts, v, w);
    end
  endtask

  task automatic check_field(string name, bit [63:0] exp_v, bit [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Result side: check each transfer, then pick the next ready level
  always @(posedge clk) begin
    pose_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_poses.size() == 0) begin
        $display("%0t unexpected pose: stamp %h", $time, out_ch.stamp_out);
        errors++;
      end else begin
        e = pending_poses.pop_front();
        check_field("stamp_out", e.stamp, out_ch.stamp_out);
        check_field("pos_x", e.x, $unsigned(out_ch.pos_x));
        check_field("pos_y", e.y, $unsigned(out_ch.pos_y));
        check_field("heading", e.hdg, out_ch.heading);
        check_field("quat_z", e.qz, $unsigned(out_ch.quat_z));
        check_field("quat_w", e.qw, $unsigned(out_ch.quat_w));
        poses_checked++;
      end
    end
    out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  dir_row_t dir_tab [15];

  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.timestamp    <= '0;
    in_ch.linear_speed <= '0;
    in_ch.turn_rate    <= '0;
    cfg_psel           <= 1'b0;
    cfg_penable        <= 1'b0;
    cfg_pwrite         <= 1'b0;
    cfg_paddr          <= '0;
    cfg_pwdata         <= '0;
    errors        = 0;
    samples_sent  = 0;
    poses_checked = 0;
    in_idle_pct   = 15;
    out_idle_pct  = 56;
    start_x = '0; start_y = '0; start_yaw = '0;
    time_seen = 1'b0; prev_stamp = '0;
    pose_x = '0; pose_y = '0; pose_yaw = '0;
    drive_stamp = '0;

    // Zero time step or no motion leaves the start pose untouched
    dir_tab = '{
      '{52'h0, 32'h0, 32'h0, 1'b0, 48'h0, 48'h0, 32'h0},  // loads pose, no result
      '{52'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1,
        48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 32'hFFFF_FFFF},
      '{52'h10_0000, 32'h0, 32'h0, 1'b1,
        48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 32'hFFFF_FFFF},
      '{52'h10_03E8, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0, '0, '0},
      '{52'h1F4, 32'h8000_0000, 32'h8000_0000, 1'b0, '0, '0, '0},  // backwards
      '{52'hF_FFFF_FFFF_FFFF, 32'h0001_0000, 32'h0, 1'b0, '0, '0, '0},
      '{52'h0, 32'hFFFF_0000, 32'h0001_0000, 1'b0, '0, '0, '0},
      '{52'hA_AAAA_AAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0, '0, '0},
      '{52'hA_AAAA_AAAA_ABAA, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, '0, '0, '0},
      '{52'hA_AAAA_AAAB_AAAA, 32'h0002_0000, 32'h0001_9220, 1'b0, '0, '0, '0},
      '{52'hA_AAAA_AABA_AAAA, 32'h0002_0000, 32'h0001_9220, 1'b0, '0, '0, '0},
      '{52'hA_AAAA_AACA_AAAA, 32'hFFFE_0000, 32'hFFFE_6DE0, 1'b0, '0, '0, '0},
      '{52'hA_AAAA_AADA_AAAA, 32'h0000_8000, 32'h0003_2440, 1'b0, '0, '0, '0},
      // time step of exactly 2^31, then one just below, pushing x to wrap
      '{52'hA_AAAB_2ADA_AAAA, 32'h7FFF_FFFF, 32'h0, 1'b0, '0, '0, '0},
      '{52'hA_AAAB_AADA_AAA9, 32'h7FFF_FFFF, 32'h0, 1'b0, '0, '0, '0}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extreme start pose: most negative x, most positive y, full heading
    set_start_pose(48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 32'hFFFF_FFFF);

    foreach (dir_tab[r]) begin
      send_sample(dir_tab[r].ts, dir_tab[r].v, dir_tab[r].w);
      if (dir_tab[r].typed) begin
        pending_poses[pending_poses.size() - 1].x   = dir_tab[r].ex;
        pending_poses[pending_poses.size() - 1].y   = dir_tab[r].ey;
        pending_poses[pending_poses.size() - 1].hdg = dir_tab[r].eh;
      end
    end
    random_phase(RandItems);

    // Registers written now must leave the running pose alone
    drain();
    set_start_pose(48'h0, 48'h0, 32'h0);
    reg_write(AddrSpare, 64'hFFFF_FFFF_FFFF_FFFF);
    in_idle_pct  = 56;
    out_idle_pct = 15;
    random_phase(RandItems);

    drain();
    set_start_pose(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 32'h8000_0000);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    random_phase(RandItems);

    drain();
    $display("Sent %0d odometry samples (directed extremes plus random steps), %0d poses",
             samples_sent, poses_checked);
    $display("checked under lazy-sink, lazy-source and back-to-back handshaking.");
    if (errors == 0 && pending_poses.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
